>>> src/metf_pkg.sv
// Package for the multijet event trigger filter: field widths, register and
// reason codes, and the structs passed between the front, back and queues.
// No dependencies.
package metf_pkg;

   localparam int PT_W       = 16;
   localparam int ETA_W      = 13;
   localparam int PHI_W      = 12;
   localparam int HT_W       = 22;
   localparam int NJ_W       = 7;
   localparam int BJ_W       = 3;
   localparam int DR_W       = 27;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam logic [HT_W-1:0] HT_MAX = {HT_W{1'b1}};

   // Jets at kept positions zero to five are the first six kept jets.
   localparam int NUM_SIX = 6;
   localparam int SIX_POS = 5;

   localparam int MAX_JETS_DEF      = 64;
   localparam int OFF_MIN_BJETS_DEF = 2;
   localparam int MID_DEPTH         = 4;
   localparam int OUT_DEPTH         = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_JET_PT   = 3'd0,
      CSR_MAX_ABS_ETA  = 3'd1,
      CSR_MIN_HT       = 3'd2,
      CSR_MIN_NUM_JETS = 3'd3,
      CSR_MIN_SIXTH_PT = 3'd4,
      CSR_MIN_BJETS    = 3'd5,
      CSR_OFFLINE_EN   = 3'd6,
      CSR_MIN_DRBB_SQ  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      REASON_PASS  = 3'd0,
      REASON_HT    = 3'd1,
      REASON_NJETS = 3'd2,
      REASON_SIXTH = 3'd3,
      REASON_BTRIG = 3'd4,
      REASON_BOFF  = 3'd5,
      REASON_DRBB  = 3'd6
   } reason_type;

   typedef struct packed {
      logic [PT_W-1:0]  min_jet_pt;
      logic [11:0]      max_abs_eta;
      logic [HT_W-1:0]  min_ht;
      logic [NJ_W-1:0]  min_num_jets;
      logic [PT_W-1:0]  min_sixth_pt;
      logic [BJ_W-1:0]  min_bjets_trigger;
      logic             offline_enable;
      logic [DR_W-1:0]  min_drbb_sq;
   } cfg_type;

   // One classified jet as it waits in the queue between front and back.
   typedef struct packed {
      logic                    kept;
      logic [PT_W-1:0]         pt;
      logic signed [ETA_W-1:0] eta;
      logic signed [PHI_W-1:0] phi;
      logic                    btag;
      logic                    last;
   } jet_type;

   typedef struct packed {
      logic             event_pass;
      reason_type       fail_reason;
      logic [HT_W-1:0]  ht_sum;
      logic [NJ_W-1:0]  kept_jets;
      logic [BJ_W-1:0]  bjets_in_six;
   } rsp_type;

endpackage

>>> src/multijet_event_trigger_filter_core.sv
// Top level of the multijet event trigger filter: register file, front end,
// jet queue, back end and result queue. Depends on metf_pkg, metf_front, metf_fifo, metf_back.
//
//   Channel   Ports          Transaction                 Handshake
//   -------   ------------   -------------------------   ------------------------
//   jets      req_*          one jet of an event         push && !full
//   results   rsp_*          one verdict per event       pop && !empty
//   config    csr_*          one register write          csr_wr_en, no wait
//
// The block sustains one jet transaction per cycle while the jet queue is not
// full; the per-jet work is one saturating add and a few compares in the back
// end's accumulator stage. After the last jet of an event is accepted, its
// verdict is formed as it leaves the jet queue into the event snapshot, passes
// the square stage, and is then written into the result queue.
// Reset is synchronous; it empties both queues, clears the event state and
// restores the register defaults.
// Either side may stall freely: the jet queue absorbs back-end stalls and the
// last jet of an event waits in it until the result queue has room.
module multijet_event_trigger_filter_core #(
   parameter int MAX_JETS      = metf_pkg::MAX_JETS_DEF,
   parameter int OFF_MIN_BJETS = metf_pkg::OFF_MIN_BJETS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Jet channel.
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [metf_pkg::PT_W-1:0]            req_jet_pt,
   input  logic signed [metf_pkg::ETA_W-1:0]    req_jet_eta,
   input  logic signed [metf_pkg::PHI_W-1:0]    req_jet_phi,
   input  logic                                 req_jet_btag,
   input  logic                                 req_last_jet,
   // Result channel.
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_event_pass,
   output logic [2:0]                           rsp_fail_reason,
   output logic [metf_pkg::HT_W-1:0]            rsp_ht_sum,
   output logic [metf_pkg::NJ_W-1:0]            rsp_kept_jets,
   output logic [metf_pkg::BJ_W-1:0]            rsp_bjets_in_six,
   // Configuration port.
   input  logic                                 csr_wr_en,
   input  logic [metf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [metf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import metf_pkg::*;

   localparam int OUT_LVL_W = $clog2(OUT_DEPTH+1);
   localparam int MID_LVL_W = $clog2(MID_DEPTH+1);

   cfg_type              cfg_ff, cfg_in;
   jet_type              mid_item, mid_head;
   logic                 mid_push, mid_pop, mid_empty, mid_full;
   logic [MID_LVL_W-1:0] mid_level;
   logic                 rsp_push, out_full;
   rsp_type              rsp_item, rsp_head;
   logic [OUT_LVL_W-1:0] out_level;

   // Register file. Writes must come only while the block is idle (it does not
   // enforce this), so the new value can be used everywhere without any hand-over.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_JET_PT:   cfg_in.min_jet_pt        = csr_wdata[PT_W-1:0];
            CSR_MAX_ABS_ETA:  cfg_in.max_abs_eta       = csr_wdata[11:0];
            CSR_MIN_HT:       cfg_in.min_ht            = csr_wdata[HT_W-1:0];
            CSR_MIN_NUM_JETS: cfg_in.min_num_jets      = csr_wdata[NJ_W-1:0];
            CSR_MIN_SIXTH_PT: cfg_in.min_sixth_pt      = csr_wdata[PT_W-1:0];
            CSR_MIN_BJETS:    cfg_in.min_bjets_trigger = csr_wdata[BJ_W-1:0];
            CSR_OFFLINE_EN:   cfg_in.offline_enable    = csr_wdata[0];
            CSR_MIN_DRBB_SQ:  cfg_in.min_drbb_sq       = csr_wdata[DR_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_jet_pt        <= '0;
         cfg_ff.max_abs_eta       <= '1;
         cfg_ff.min_ht            <= '0;
         cfg_ff.min_num_jets      <= NJ_W'(NUM_SIX);
         cfg_ff.min_sixth_pt      <= '0;
         cfg_ff.min_bjets_trigger <= '0;
         cfg_ff.offline_enable    <= 1'b0;
         cfg_ff.min_drbb_sq       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: selection cuts on each incoming jet.
   metf_front u_front (
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_jet_pt   (req_jet_pt),
      .req_jet_eta  (req_jet_eta),
      .req_jet_phi  (req_jet_phi),
      .req_jet_btag (req_jet_btag),
      .req_last_jet (req_last_jet),
      .mid_full     (mid_full),
      .req_full     (req_full),
      .mid_push     (mid_push),
      .mid_item     (mid_item)
   );

   // Queue of classified jets between the two halves.
   metf_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(jet_type))
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_item),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty),
      .full      (mid_full),
      .level     (mid_level)
   );

   // Back end: event accumulation and the cut decision.
   metf_back #(
      .MAX_JETS      (MAX_JETS),
      .OFF_MIN_BJETS (OFF_MIN_BJETS),
      .OUT_DEPTH     (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (mid_head),
      .mid_empty (mid_empty || (mid_level == '0)),
      .out_level (out_level),
      .mid_pop   (mid_pop),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   // Result queue. The back end reserves space before a verdict is started,
   // so a push never meets a full queue.
   metf_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty),
      .full      (out_full),
      .level     (out_level)
   );

   assign rsp_event_pass   = rsp_head.event_pass && !out_full || rsp_head.event_pass;
   assign rsp_fail_reason  = rsp_head.fail_reason;
   assign rsp_ht_sum       = rsp_head.ht_sum;
   assign rsp_kept_jets    = rsp_head.kept_jets;
   assign rsp_bjets_in_six = rsp_head.bjets_in_six;

endmodule

>>> src/metf_fifo.sv
// Small synchronous FIFO used for the jet queue and the result queue.
// Depends on nothing; the payload is a plain vector of WIDTH bits.
module metf_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           empty,
   output logic                           full,
   output logic [$clog2(DEPTH+1)-1:0]     level
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign level    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/metf_front.sv
// Front end of the trigger filter: takes jet transactions and applies the
// pt and |eta| selection. Depends on metf_pkg.
module metf_front (
   input  metf_pkg::cfg_type                    cfg,
   input  logic                                 req_push,
   input  logic [metf_pkg::PT_W-1:0]            req_jet_pt,
   input  logic signed [metf_pkg::ETA_W-1:0]    req_jet_eta,
   input  logic signed [metf_pkg::PHI_W-1:0]    req_jet_phi,
   input  logic                                 req_jet_btag,
   input  logic                                 req_last_jet,
   input  logic                                 mid_full,
   output logic                                 req_full,
   output logic                                 mid_push,
   output metf_pkg::jet_type                    mid_item
);
   import metf_pkg::*;

   logic [ETA_W-1:0] abs_eta;

   // The magnitude of the most negative eta still fits in ETA_W unsigned bits.
   assign abs_eta  = req_jet_eta[ETA_W-1] ? (~req_jet_eta + 1'b1) : req_jet_eta;

   assign req_full = mid_full;
   assign mid_push = req_push && !mid_full;

   always_comb begin
      mid_item.kept = (req_jet_pt >= cfg.min_jet_pt) &&
                      (abs_eta <= {1'b0, cfg.max_abs_eta});
      mid_item.pt   = req_jet_pt;
      mid_item.eta  = req_jet_eta;
      mid_item.phi  = req_jet_phi;
      mid_item.btag = req_jet_btag;
      mid_item.last = req_last_jet;
   end

endmodule

>>> src/metf_back.sv
// Back end of the trigger filter: per-event accumulation and the three-stage
// decision pipeline that yields one result per event. Depends on metf_pkg.
module metf_back #(
   parameter int MAX_JETS      = metf_pkg::MAX_JETS_DEF,
   parameter int OFF_MIN_BJETS = metf_pkg::OFF_MIN_BJETS_DEF,
   parameter int OUT_DEPTH     = metf_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  metf_pkg::cfg_type                  cfg,
   input  metf_pkg::jet_type                  head,
   input  logic                               mid_empty,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
   output logic                               mid_pop,
   output logic                               rsp_push,
   output metf_pkg::rsp_type                  rsp_item
);
   import metf_pkg::*;

   localparam int KCW_RAW = $clog2(MAX_JETS+1);
   localparam int KCW     = (KCW_RAW > NJ_W) ? KCW_RAW : NJ_W;
   localparam int LVL_W   = $clog2(OUT_DEPTH+1);

   // Event accumulators.
   logic [KCW-1:0]          kept_cnt_ff, kept_cnt_in, kept_next;
   logic [HT_W-1:0]         ht_ff, ht_in, ht_next;
   logic [PT_W-1:0]         sixth_ff, sixth_in, sixth_next;
   logic [BJ_W-1:0]         bcnt_ff, bcnt_in, bcnt_next;
   logic signed [ETA_W-1:0] eta0_ff, eta0_in, eta0_next;
   logic signed [ETA_W-1:0] eta1_ff, eta1_in, eta1_next;
   logic signed [PHI_W-1:0] phi0_ff, phi0_in, phi0_next;
   logic signed [PHI_W-1:0] phi1_ff, phi1_in, phi1_next;

   // Stage one: snapshot of a finished event.
   logic                    s1_valid_ff, s1_valid_in;
   logic [KCW-1:0]          s1_kept_ff;
   logic [HT_W-1:0]         s1_ht_ff;
   logic [PT_W-1:0]         s1_sixth_ff;
   logic [BJ_W-1:0]         s1_bcnt_ff;
   logic signed [ETA_W-1:0] s1_eta0_ff, s1_eta1_ff;
   logic signed [PHI_W-1:0] s1_phi0_ff, s1_phi1_ff;

   // Stage two: squares and the early cut decision.
   logic                    s2_valid_ff;
   reason_type              s2_reason_ff, s2_reason_in;
   logic                    s2_need_dr_ff, s2_need_dr_in;
   logic [DR_W-1:0]         s2_sq_eta_ff, s2_sq_eta_in;
   logic [22:0]             s2_sq_phi_ff, s2_sq_phi_in;
   logic [HT_W-1:0]         s2_ht_ff;
   logic [NJ_W-1:0]         s2_kept_ff;
   logic [BJ_W-1:0]         s2_bcnt_ff;

   logic                    credit_ok, take, under6, bhit;
   logic [LVL_W:0]          in_flight;
   logic [HT_W:0]           ht_sum;
   logic signed [ETA_W:0]   deta;
   logic signed [PHI_W-1:0] dphi;
   logic signed [2*ETA_W+1:0] deta_prod;
   logic signed [2*PHI_W-1:0] dphi_prod;
   logic [DR_W:0]           dr_sum;
   reason_type              final_reason;

   // A last jet may enter only when the result queue has room for it and
   // for every result still in the pipeline.
   assign in_flight = {1'b0, out_level} + (LVL_W+1)'(s1_valid_ff) + (LVL_W+1)'(s2_valid_ff);
   assign credit_ok = in_flight < (LVL_W+1)'(OUT_DEPTH);
   assign mid_pop   = !mid_empty && (!head.last || credit_ok);

   always_comb begin
      take   = mid_pop && head.kept;
      under6 = kept_cnt_ff < KCW'(NUM_SIX);
      bhit   = take && under6 && head.btag;
      ht_sum = {1'b0, ht_ff} + (HT_W+1)'(head.pt);

      ht_next    = ht_ff;
      kept_next  = kept_cnt_ff;
      sixth_next = sixth_ff;
      bcnt_next  = bcnt_ff;
      eta0_next  = eta0_ff;
      eta1_next  = eta1_ff;
      phi0_next  = phi0_ff;
      phi1_next  = phi1_ff;
      if (take) begin
         ht_next = ht_sum[HT_W] ? HT_MAX : ht_sum[HT_W-1:0];
         if (kept_cnt_ff < KCW'(MAX_JETS)) begin
            kept_next = kept_cnt_ff + 1'b1;
         end
         if (kept_cnt_ff == KCW'(SIX_POS)) begin
            sixth_next = head.pt;
         end
      end
      if (bhit) begin
         bcnt_next = bcnt_ff + 1'b1;
         if (bcnt_ff == BJ_W'(0)) begin
            eta0_next = head.eta;
            phi0_next = head.phi;
         end else if (bcnt_ff == BJ_W'(1)) begin
            eta1_next = head.eta;
            phi1_next = head.phi;
         end
      end

      s1_valid_in = mid_pop && head.last;
      if (s1_valid_in) begin
         // The event is complete: clear for the next one.
         ht_in       = '0;
         kept_cnt_in = '0;
         sixth_in    = '0;
         bcnt_in     = '0;
         eta0_in     = '0;
         eta1_in     = '0;
         phi0_in     = '0;
         phi1_in     = '0;
      end else begin
         ht_in       = ht_next;
         kept_cnt_in = kept_next;
         sixth_in    = sixth_next;
         bcnt_in     = bcnt_next;
         eta0_in     = eta0_next;
         eta1_in     = eta1_next;
         phi0_in     = phi0_next;
         phi1_in     = phi1_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_cnt_ff <= '0;
         ht_ff       <= '0;
         sixth_ff    <= '0;
         bcnt_ff     <= '0;
         eta0_ff     <= '0;
         eta1_ff     <= '0;
         phi0_ff     <= '0;
         phi1_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         kept_cnt_ff <= kept_cnt_in;
         ht_ff       <= ht_in;
         sixth_ff    <= sixth_in;
         bcnt_ff     <= bcnt_in;
         eta0_ff     <= eta0_in;
         eta1_ff     <= eta1_in;
         phi0_ff     <= phi0_in;
         phi1_ff     <= phi1_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_kept_ff  <= kept_next;
         s1_ht_ff    <= ht_next;
         s1_sixth_ff <= sixth_next;
         s1_bcnt_ff  <= bcnt_next;
         s1_eta0_ff  <= eta0_next;
         s1_eta1_ff  <= eta1_next;
         s1_phi0_ff  <= phi0_next;
         s1_phi1_ff  <= phi1_next;
      end
   end

   // Stage two: the phi difference wraps naturally in PHI_W bits.
   always_comb begin
      deta         = {s1_eta0_ff[ETA_W-1], s1_eta0_ff} - {s1_eta1_ff[ETA_W-1], s1_eta1_ff};
      dphi         = s1_phi0_ff - s1_phi1_ff;
      deta_prod    = deta * deta;
      dphi_prod    = dphi * dphi;
      s2_sq_eta_in = deta_prod[DR_W-1:0];
      s2_sq_phi_in = dphi_prod[22:0];

      s2_need_dr_in = 1'b0;
      if (s1_ht_ff < cfg.min_ht) begin
         s2_reason_in = REASON_HT;
      end else if (s1_kept_ff < KCW'(cfg.min_num_jets)) begin
         s2_reason_in = REASON_NJETS;
      end else if (s1_sixth_ff < cfg.min_sixth_pt) begin
         s2_reason_in = REASON_SIXTH;
      end else if (s1_bcnt_ff < cfg.min_bjets_trigger) begin
         s2_reason_in = REASON_BTRIG;
      end else if (cfg.offline_enable && (s1_bcnt_ff < BJ_W'(OFF_MIN_BJETS))) begin
         s2_reason_in = REASON_BOFF;
      end else begin
         s2_reason_in  = REASON_PASS;
         s2_need_dr_in = cfg.offline_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_reason_ff  <= s2_reason_in;
         s2_need_dr_ff <= s2_need_dr_in;
         s2_sq_eta_ff  <= s2_sq_eta_in;
         s2_sq_phi_ff  <= s2_sq_phi_in;
         s2_ht_ff      <= s1_ht_ff;
         s2_kept_ff    <= s1_kept_ff[NJ_W-1:0];
         s2_bcnt_ff    <= s1_bcnt_ff;
      end
   end

   // Stage three: the deltaR sum and compare, straight into the result queue.
   always_comb begin
      dr_sum = {1'b0, s2_sq_eta_ff} + (DR_W+1)'(s2_sq_phi_ff);
      if (s2_need_dr_ff && (dr_sum < {1'b0, cfg.min_drbb_sq})) begin
         final_reason = REASON_DRBB;
      end else begin
         final_reason = s2_reason_ff;
      end
      rsp_item.event_pass   = (final_reason == REASON_PASS);
      rsp_item.fail_reason  = final_reason;
      rsp_item.ht_sum       = s2_ht_ff;
      rsp_item.kept_jets    = s2_kept_ff;
      rsp_item.bjets_in_six = s2_bcnt_ff;
   end

   assign rsp_push = s2_valid_ff;

endmodule

>>> src/metf_checker.sv
// Port-level checks for the multijet event trigger filter, attached to the
// top level by the bind statement at the end. Depends on metf_pkg.
module metf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic                          rsp_event_pass,
   input logic [2:0]                    rsp_fail_reason,
   input logic [metf_pkg::NJ_W-1:0]     rsp_kept_jets,
   input logic [metf_pkg::BJ_W-1:0]     rsp_bjets_in_six
);
   import metf_pkg::*;

   // Reset empties both queues.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // The pass flag and the reason code always agree.
   a_pass_matches_reason: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_event_pass == (rsp_fail_reason == REASON_PASS)))
      else $error("event_pass disagrees with fail_reason");

   // Only defined reasons and at most six b-jets among the first six.
   a_result_ranges: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_fail_reason <= REASON_DRBB) &&
                     (rsp_bjets_in_six <= BJ_W'(NUM_SIX)))
      else $error("result field out of range");

   // A waiting verdict is held until it is taken.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_fail_reason) &&
                                 $stable(rsp_kept_jets))
      else $error("waiting result changed before pop");

endmodule

bind multijet_event_trigger_filter_core metf_checker u_metf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_event_pass   (rsp_event_pass),
   .rsp_fail_reason  (rsp_fail_reason),
   .rsp_kept_jets    (rsp_kept_jets),
   .rsp_bjets_in_six (rsp_bjets_in_six)
);
